[design/pxo_pkg.sv]
// Shared types, constants and helpers for the 3x3 pixel outline block.
package pxo_pkg;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned OUTQ_DEPTH = 4;
  localparam int unsigned OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int unsigned OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  localparam logic [PIX_W-1:0] FG_RESET = 8'd192;
  localparam logic [PIX_W-1:0] OL_RESET = 8'd213;
  localparam logic [PIX_W-1:0] BG_RESET = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FOREGROUND = 2'd0,
    REG_OUTLINE    = 2'd1,
    REG_BACKGROUND = 2'd2,
    REG_UNUSED     = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [PIX_W-1:0] above;
    logic [PIX_W-1:0] centre;
    logic [PIX_W-1:0] below;
  } pxo_col_t;

  // what a window cell exposes to the decision logic
  typedef struct packed {
    pxo_col_t col;
    logic     fg_any;
    logic     fg_edge;
  } pxo_tap_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             outlined;
    logic             row_end;
  } pxo_result_t;

  function automatic logic col_has_fg(pxo_col_t col, logic [PIX_W-1:0] fg);
    return (col.above == fg) || (col.centre == fg) || (col.below == fg);
  endfunction

endpackage

[design/pxo_cell.sv]
// Window cell: holds one pixel column and flags foreground matches in it.
module pxo_cell import pxo_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  pxo_col_t         col_i,
  input  logic [PIX_W-1:0] fg_i,
  output pxo_tap_t         tap_o
);

  pxo_col_t col_q;
  pxo_col_t col_d;

  assign col_d = load_i ? col_i : col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else begin
      col_q <= col_d;
    end
  end

  assign tap_o.col     = col_q;
  assign tap_o.fg_any  = col_has_fg(col_q, fg_i);
  assign tap_o.fg_edge = (col_q.above == fg_i) || (col_q.below == fg_i);

endmodule

[design/pxo_outq.sv]
// Result queue: takes up to two result beats per cycle, hands out one while ready_i is high.
module pxo_outq import pxo_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [1:0]  push_cnt_i,
  input  pxo_result_t push_a_i,
  input  pxo_result_t push_b_i,
  output logic        space2_o,
  output logic        valid_o,
  input  logic        ready_i,
  output pxo_result_t data_o
);

  pxo_result_t               mem_q [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [OUTQ_PTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [OUTQ_CNT_W-1:0]     cnt_q, cnt_d;
  logic [OUTQ_PTR_W-1:0]     wr_ptr_b;
  logic                      pop;

  assign pop      = valid_o && ready_i;
  assign wr_ptr_b = wr_ptr_q + OUTQ_PTR_W'(1);
  assign wr_ptr_d = wr_ptr_q + OUTQ_PTR_W'(push_cnt_i);
  assign rd_ptr_d = rd_ptr_q + OUTQ_PTR_W'(pop);
  assign cnt_d    = cnt_q + OUTQ_CNT_W'(push_cnt_i) - OUTQ_CNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push_a_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr_b] <= push_b_i;
    end
  end

  assign space2_o = cnt_q <= OUTQ_CNT_W'(OUTQ_DEPTH - 2);
  assign valid_o  = cnt_q != '0;
  assign data_o   = mem_q[rd_ptr_q];

endmodule

[design/pixel_outline_3x3.sv]
// Top level of the streaming 3x3 pixel outline block.
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+-----------------------------------------
//  in      | in_valid_i  | in_ready_o  | pixel_above/centre/below_i, row_first/last_i
//  out     | out_valid_o | out_ready_i | pixel_out_o, outlined_o, row_end_o
//  cfg     | cfg_valid_i | cfg_ready_o | cfg_index_i, cfg_data_i
//
// One column beat per cycle while in_ready_o is high; a column with the row_last
// flag yields two result beats when the window already holds a column, so the
// output can fall behind the input. Results pass through a four-entry queue;
// input is taken while the queue has room for two beats. Reset clears the
// window, the column count and the queue, and loads the default colours.
// Config writes are always accepted, as cfg_ready_o is tied high.
module pixel_outline_3x3 import pxo_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [PIX_W-1:0]     pixel_above_i,
  input  logic [PIX_W-1:0]     pixel_centre_i,
  input  logic [PIX_W-1:0]     pixel_below_i,
  input  logic                 row_first_i,
  input  logic                 row_last_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [PIX_W-1:0]     pixel_out_o,
  output logic                 outlined_o,
  output logic                 row_end_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [PIX_W-1:0]     cfg_data_i
);

  logic [PIX_W-1:0] fg_q, ol_q, bg_q;
  logic [1:0]       seen_q, seen_d;
  logic [1:0]       n;
  logic             accept;
  pxo_col_t         col_in;
  pxo_tap_t         tap_mid, tap_left;
  logic             hit;
  pxo_result_t      res0, res1, push_a, push_b;
  logic             res0_v;
  logic [1:0]       push_cnt;
  logic             space2;
  pxo_result_t      out_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= FG_RESET;
      ol_q <= OL_RESET;
      bg_q <= BG_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_FOREGROUND: fg_q <= cfg_data_i;
        REG_OUTLINE:    ol_q <= cfg_data_i;
        REG_BACKGROUND: bg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = space2;
  assign accept     = in_valid_i && space2;

  assign col_in.above  = pixel_above_i;
  assign col_in.centre = pixel_centre_i;
  assign col_in.below  = pixel_below_i;

  assign n = row_first_i ? 2'd0 : ((seen_q == 2'd3) ? 2'd2 : seen_q);

  always_comb begin
    if (row_last_i) begin
      seen_d = 2'd0;
    end else begin
      seen_d = (n == 2'd2) ? 2'd2 : n + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else if (accept) begin
      seen_q <= seen_d;
    end
  end

  // middle cell takes the new column, left cell takes the middle one
  pxo_cell u_mid (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (accept),
    .col_i  (col_in),
    .fg_i   (fg_q),
    .tap_o  (tap_mid)
  );

  pxo_cell u_left (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (accept && (n != 2'd0)),
    .col_i  (tap_mid.col),
    .fg_i   (fg_q),
    .tap_o  (tap_left)
  );

  assign hit = tap_left.fg_any || tap_mid.fg_edge || col_has_fg(col_in, fg_q);

  always_comb begin
    res0.row_end = 1'b0;
    if ((n == 2'd2) && (tap_mid.col.centre == bg_q) && hit) begin
      res0.pixel    = ol_q;
      res0.outlined = 1'b1;
    end else begin
      res0.pixel    = tap_mid.col.centre;
      res0.outlined = 1'b0;
    end
  end

  assign res1.pixel    = pixel_centre_i;
  assign res1.outlined = 1'b0;
  assign res1.row_end  = 1'b1;

  assign res0_v = n != 2'd0;

  always_comb begin
    push_cnt = 2'd0;
    push_a   = res0;
    push_b   = res1;
    if (accept) begin
      push_cnt = {1'b0, res0_v} + {1'b0, row_last_i};
      if (!res0_v) begin
        push_a = res1;
      end
    end
  end

  pxo_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .push_a_i   (push_a),
    .push_b_i   (push_b),
    .space2_o   (space2),
    .valid_o    (out_valid_o),
    .ready_i    (out_ready_i),
    .data_o     (out_data)
  );

  assign pixel_out_o = out_data.pixel;
  assign outlined_o  = out_data.outlined;
  assign row_end_o   = out_data.row_end;

endmodule

[bench/tb_top.sv]
// Self-checking testbench for the pixel_outline_3x3 streaming outline block.
`timescale 1ns / 1ps

module tb_top;
  import pxo_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 6;
  localparam int BLOCK_ITEMS   = 147;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [PIX_W-1:0]     pixel_above_i;
  logic [PIX_W-1:0]     pixel_centre_i;
  logic [PIX_W-1:0]     pixel_below_i;
  logic                 row_first_i;
  logic                 row_last_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [PIX_W-1:0]     pixel_out_o;
  logic                 outlined_o;
  logic                 row_end_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  cfg_reg_e             cfg_index_i;
  logic [PIX_W-1:0]     cfg_data_i;

  pixel_outline_3x3 dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .pixel_above_i  (pixel_above_i),
    .pixel_centre_i (pixel_centre_i),
    .pixel_below_i  (pixel_below_i),
    .row_first_i    (row_first_i),
    .row_last_i     (row_last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_out_o    (pixel_out_o),
    .outlined_o     (outlined_o),
    .row_end_o      (row_end_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // shadow of the block
  logic [PIX_W-1:0] fg_colour;
  logic [PIX_W-1:0] ol_colour;
  logic [PIX_W-1:0] bg_colour;
  pxo_col_t         win_left;
  pxo_col_t         win_mid;
  logic [1:0]       cols_held;

  pxo_result_t expected_pixels[$];
  int          errors;
  int          cycle_count;
  int          src_idle_pct;
  int          sink_idle_pct;
  logic        row_open;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic holds_fg(pxo_col_t col);
    return (col.above == fg_colour) || (col.centre == fg_colour) || (col.below == fg_colour);
  endfunction

  function automatic void predict_column(pxo_col_t col, logic first, logic last);
    logic [1:0]  n;
    logic        hit;
    pxo_result_t r;
    n = first ? 2'd0 : cols_held;
    if (n == 2'd3) n = 2'd2;
    if (n == 2'd1) begin
      r = '{pixel: win_mid.centre, outlined: 1'b0, row_end: 1'b0};
      expected_pixels.push_back(r);
    end else if (n == 2'd2) begin
      hit = holds_fg(win_left) || holds_fg(col) ||
            (win_mid.above == fg_colour) || (win_mid.below == fg_colour);
      if (win_mid.centre == bg_colour && hit) begin
        r = '{pixel: ol_colour, outlined: 1'b1, row_end: 1'b0};
      end else begin
        r = '{pixel: win_mid.centre, outlined: 1'b0, row_end: 1'b0};
      end
      expected_pixels.push_back(r);
    end
    if (n != 2'd0) win_left = win_mid;
    win_mid = col;
    if (last) begin
      r = '{pixel: col.centre, outlined: 1'b0, row_end: 1'b1};
      expected_pixels.push_back(r);
      cols_held = 2'd0;
    end else begin
      cols_held = (n < 2'd2) ? n + 2'd1 : 2'd2;
    end
  endfunction

  // track colour writes, predict on accepted input beats, check accepted result beats
  always @(posedge clk_i) begin
    pxo_result_t exp_r;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_FOREGROUND: fg_colour = cfg_data_i;
          REG_OUTLINE:    ol_colour = cfg_data_i;
          REG_BACKGROUND: bg_colour = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        predict_column('{above: pixel_above_i, centre: pixel_centre_i, below: pixel_below_i},
                       row_first_i, row_last_i);
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_pixels.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat pixel %0d outlined %0b row_end %0b",
                   $time, pixel_out_o, outlined_o, row_end_o);
        end else begin
          exp_r = expected_pixels.pop_front();
          if (pixel_out_o !== exp_r.pixel) begin
            errors++;
            $display("%0t: pixel_out expected %0d got %0d", $time, exp_r.pixel, pixel_out_o);
          end
          if (outlined_o !== exp_r.outlined) begin
            errors++;
            $display("%0t: outlined expected %0b got %0b", $time, exp_r.outlined, outlined_o);
          end
          if (row_end_o !== exp_r.row_end) begin
            errors++;
            $display("%0t: row_end expected %0b got %0b", $time, exp_r.row_end, row_end_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i = ($urandom_range(99) >= sink_idle_pct);
  end

  task automatic send_column(pxo_col_t col, logic first, logic last);
    @(negedge clk_i);
    // before each beat, every cycle idles with the set odds
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    pixel_above_i  = col.above;
    pixel_centre_i = col.centre;
    pixel_below_i  = col.below;
    row_first_i    = first;
    row_last_i     = last;
    do @(posedge clk_i); while (!in_ready_o);
    row_open = !last;
  endtask

  task automatic send_pixels(logic [7:0] a, logic [7:0] c, logic [7:0] b,
                             logic first, logic last);
    send_column('{above: a, centre: c, below: b}, first, last);
  endtask

  // sender holds off until every result is out and the pipe has settled
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_colour(cfg_reg_e idx, logic [7:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(9))
      0, 1, 2: return fg_colour;
      3, 4, 5: return bg_colour;
      6:       return ol_colour;
      7:       return 8'h00;
      8:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_colour();
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic test_short_rows();
    // reset colours: fg 192, outline 213, bg 255
    send_pixels(8'd255, 8'd255, 8'd255, 1'b1, 1'b1);
    send_pixels(8'd192, 8'd255, 8'd192, 1'b1, 1'b0);
    send_pixels(8'd0,   8'd255, 8'd0,   1'b0, 1'b1);
    send_pixels(8'd0,   8'd0,   8'd0,   1'b1, 1'b0);
    send_pixels(8'd192, 8'd255, 8'd0,   1'b0, 1'b0);
    send_pixels(8'd255, 8'd255, 8'd255, 1'b0, 1'b1);
    // new row without row_first
    send_pixels(8'd255, 8'd0,   8'd255, 1'b0, 1'b0);
    send_pixels(8'd0,   8'd255, 8'd0,   1'b0, 1'b0);
    send_pixels(8'd0,   8'd0,   8'd192, 1'b0, 1'b1);
    wait_drained();
  endtask

  task automatic test_row_markers();
    // row_first mid-row drops the pending column
    send_pixels(8'd1,   8'd2,   8'd3,   1'b1, 1'b0);
    send_pixels(8'd4,   8'd255, 8'd6,   1'b0, 1'b0);
    send_pixels(8'd192, 8'd8,   8'd9,   1'b0, 1'b0);
    send_pixels(8'd10,  8'd255, 8'd12,  1'b1, 1'b0);
    send_pixels(8'd13,  8'd255, 8'd192, 1'b0, 1'b0);
    send_pixels(8'd255, 8'd255, 8'd255, 1'b0, 1'b1);
    // background centre without foreground, foreground centre only
    send_pixels(8'd255, 8'd255, 8'd255, 1'b1, 1'b0);
    send_pixels(8'd192, 8'd192, 8'd192, 1'b0, 1'b0);
    send_pixels(8'd192, 8'd192, 8'd192, 1'b1, 1'b1);
    wait_drained();
  endtask

  task automatic test_colour_registers();
    write_colour(REG_UNUSED,     8'hAA);
    write_colour(REG_FOREGROUND, 8'h00);
    write_colour(REG_OUTLINE,    8'hFF);
    write_colour(REG_BACKGROUND, 8'h00);
    send_pixels(8'h00, 8'h00, 8'hFF, 1'b1, 1'b0);
    send_pixels(8'hFF, 8'h00, 8'hFF, 1'b0, 1'b0);
    send_pixels(8'hFF, 8'h00, 8'hFF, 1'b0, 1'b1);
    wait_drained();
    write_colour(REG_FOREGROUND, 8'hFF);
    write_colour(REG_OUTLINE,    8'h00);
    write_colour(REG_BACKGROUND, 8'hFF);
    send_pixels(8'h00, 8'hFF, 8'h00, 1'b1, 1'b0);
    send_pixels(8'h00, 8'hFF, 8'hFF, 1'b0, 1'b0);
    send_pixels(8'hFF, 8'hFF, 8'h00, 1'b0, 1'b1);
    wait_drained();
  endtask

  task automatic send_random_rows(int n_items);
    int       sent;
    int       len;
    int       k;
    logic     noisy;
    pxo_col_t col;
    sent = 0;
    while (sent < n_items) begin
      len   = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
      noisy = ($urandom_range(99) < 15);
      for (k = 0; k < len; k++) begin
        col = '{above: pick_pixel(), centre: pick_pixel(), below: pick_pixel()};
        if (noisy) begin
          send_column(col, $urandom_range(7) == 0, $urandom_range(7) == 0);
        end else begin
          send_column(col, (k == 0) && ($urandom_range(3) != 0), k == len - 1);
        end
        sent++;
      end
    end
    // close any open row so the window is empty before new colours
    if (row_open) begin
      col = '{above: pick_pixel(), centre: pick_pixel(), below: pick_pixel()};
      send_column(col, 1'b0, 1'b1);
    end
  endtask

  task automatic run_random_phase(int src_pct, int sink_pct);
    int blk;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    for (blk = 0; blk < 3; blk++) begin
      wait_drained();
      write_colour(REG_FOREGROUND, pick_colour());
      write_colour(REG_OUTLINE,    pick_colour());
      if ($urandom_range(4) == 0) begin
        write_colour(REG_BACKGROUND, fg_colour);
      end else begin
        write_colour(REG_BACKGROUND, pick_colour());
      end
      send_random_rows(BLOCK_ITEMS);
    end
  endtask

  task automatic test_random_stream();
    run_random_phase(26, 86);
    run_random_phase(86, 26);
    run_random_phase(0, 0);
  endtask

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    out_ready_i    = 1'b0;
    pixel_above_i  = '0;
    pixel_centre_i = '0;
    pixel_below_i  = '0;
    row_first_i    = 1'b0;
    row_last_i     = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = REG_FOREGROUND;
    cfg_data_i     = '0;
    fg_colour      = FG_RESET;
    ol_colour      = OL_RESET;
    bg_colour      = BG_RESET;
    win_left       = '0;
    win_mid        = '0;
    cols_held      = 2'd0;
    errors         = 0;
    cycle_count    = 0;
    src_idle_pct   = 0;
    sink_idle_pct  = 0;
    row_open       = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_short_rows();
    test_row_markers();
    test_colour_registers();
    test_random_stream();

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
